### sv/cpl_pkg.sv
`timescale 1ns / 1ps

package cpl_pkg;

	localparam int MOTORS_DEF        = 4;
	localparam int ANGLE_LIMIT_DEF   = 5000;
	localparam int SPEED_LIMIT_DEF   = 1000;
	localparam int CURRENT_LIMIT_DEF = 3000;

	localparam int NUM_REGS  = 8;
	localparam int REG_W     = 32;
	localparam int REG_IDX_W = 3;
	localparam int LIM_W     = 16;
	localparam int PC_W      = 4;

	localparam logic [REG_W-1:0] CURRENT_KD_FIXED = 32'd83886080;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_ANGLE_KP,
		REG_ANGLE_KI,
		REG_ANGLE_KD,
		REG_SPEED_KP,
		REG_SPEED_KI,
		REG_SPEED_KD,
		REG_CURRENT_KP,
		REG_CURRENT_KI
	} reg_idx_t;

	typedef enum logic [1:0] {
		STG_ANGLE,
		STG_SPEED,
		STG_CURRENT
	} stage_t;

	typedef enum logic [1:0] {
		TERM_P,
		TERM_I,
		TERM_D
	} term_t;

	typedef enum logic [2:0] {
		COND_NEXT,
		COND_NO_INPUT,
		COND_BAD_MOTOR,
		COND_MORE,
		COND_OUT_BUSY,
		COND_ALWAYS
	} cond_t;

	typedef logic [PC_W-1:0] pc_t;

	localparam pc_t STEP_WAIT      = 4'd0;
	localparam pc_t STEP_RANGE     = 4'd1;
	localparam pc_t STEP_ERR       = 4'd2;
	localparam pc_t STEP_MUL_P     = 4'd3;
	localparam pc_t STEP_MUL_I     = 4'd4;
	localparam pc_t STEP_MUL_D     = 4'd5;
	localparam pc_t STEP_ACC       = 4'd6;
	localparam pc_t STEP_ROUND     = 4'd7;
	localparam pc_t STEP_OUT_WAIT  = 4'd8;
	localparam pc_t STEP_OUT       = 4'd9;
	localparam pc_t STEP_ZERO_WAIT = 4'd10;
	localparam pc_t STEP_ZERO      = 4'd11;

	typedef struct packed {
		logic  take;
		logic  stage_clr;
		logic  err_en;
		logic  acc_clr;
		logic  mul_en;
		term_t term;
		logic  acc_en;
		logic  wb_en;
		logic  stage_inc;
		logic  out_en;
		logic  out_zero;
		cond_t cond;
		pc_t   target;
	} uword_t;

	typedef struct packed {
		uword_t uw;
		stage_t stage;
		logic   load;
	} dp_ctl_t;

	typedef struct packed {
		logic bad_motor;
		logic out_busy;
	} dp_stat_t;

	function automatic logic [REG_W-1:0] reg_reset(input reg_idx_t idx);
		logic [REG_W-1:0] v;
		unique case (idx)
			REG_ANGLE_KP:   v = 32'd25165824;
			REG_ANGLE_KI:   v = 32'd1678;
			REG_ANGLE_KD:   v = 32'd838860800;
			REG_SPEED_KP:   v = 32'd15099494;
			REG_SPEED_KI:   v = 32'd839;
			REG_SPEED_KD:   v = 32'd335544320;
			REG_CURRENT_KP: v = 32'd8388608;
			REG_CURRENT_KI: v = 32'd168;
		endcase
		return v;
	endfunction

	function automatic uword_t ucode(input pc_t pc);
		uword_t w;
		w = '0;
		unique case (pc)
			STEP_WAIT: begin
				w.take   = 1'b1;
				w.cond   = COND_NO_INPUT;
				w.target = STEP_WAIT;
			end
			STEP_RANGE: begin
				w.stage_clr = 1'b1;
				w.cond      = COND_BAD_MOTOR;
				w.target    = STEP_ZERO_WAIT;
			end
			STEP_ERR: begin
				w.err_en  = 1'b1;
				w.acc_clr = 1'b1;
			end
			STEP_MUL_P: begin
				w.mul_en = 1'b1;
				w.term   = TERM_P;
			end
			STEP_MUL_I: begin
				w.mul_en = 1'b1;
				w.term   = TERM_I;
				w.acc_en = 1'b1;
			end
			STEP_MUL_D: begin
				w.mul_en = 1'b1;
				w.term   = TERM_D;
				w.acc_en = 1'b1;
			end
			STEP_ACC: begin
				w.acc_en = 1'b1;
			end
			STEP_ROUND: begin
				w.wb_en     = 1'b1;
				w.stage_inc = 1'b1;
				w.cond      = COND_MORE;
				w.target    = STEP_ERR;
			end
			STEP_OUT_WAIT: begin
				w.cond   = COND_OUT_BUSY;
				w.target = STEP_OUT_WAIT;
			end
			STEP_OUT: begin
				w.out_en = 1'b1;
				w.cond   = COND_ALWAYS;
				w.target = STEP_WAIT;
			end
			STEP_ZERO_WAIT: begin
				w.cond   = COND_OUT_BUSY;
				w.target = STEP_ZERO_WAIT;
			end
			STEP_ZERO: begin
				w.out_en   = 1'b1;
				w.out_zero = 1'b1;
				w.cond     = COND_ALWAYS;
				w.target   = STEP_WAIT;
			end
			default: begin
				w.cond   = COND_ALWAYS;
				w.target = STEP_WAIT;
			end
		endcase
		return w;
	endfunction

endpackage

### sv/cpl_seq.sv
`timescale 1ns / 1ps

module cpl_seq import cpl_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  dp_stat_t stat,
	output logic     in_ready,
	output dp_ctl_t  ctl
);

	pc_t    pc_q;
	pc_t    pc_d;
	stage_t stage_q;
	stage_t stage_d;
	uword_t uw;
	logic   jump;

	assign uw       = ucode(pc_q);
	assign in_ready = uw.take;

	always_comb begin
		case (uw.cond)
			COND_NEXT:      jump = 1'b0;
			COND_NO_INPUT:  jump = ~in_valid;
			COND_BAD_MOTOR: jump = stat.bad_motor;
			COND_MORE:      jump = (stage_q != STG_CURRENT);
			COND_OUT_BUSY:  jump = stat.out_busy;
			COND_ALWAYS:    jump = 1'b1;
			default:        jump = 1'b1;
		endcase
		pc_d = jump ? uw.target : pc_q + 1'b1;
	end

	always_comb begin
		stage_d = stage_q;
		if (uw.stage_clr) begin
			stage_d = STG_ANGLE;
		end else if (uw.stage_inc) begin
			case (stage_q)
				STG_ANGLE: stage_d = STG_SPEED;
				STG_SPEED: stage_d = STG_CURRENT;
				default:   stage_d = STG_ANGLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q    <= STEP_WAIT;
			stage_q <= STG_ANGLE;
		end else begin
			pc_q    <= pc_d;
			stage_q <= stage_d;
		end
	end

	assign ctl.uw    = uw;
	assign ctl.stage = stage_q;
	assign ctl.load  = uw.take & in_valid;

endmodule

### sv/cpl_dp.sv
`timescale 1ns / 1ps

module cpl_dp import cpl_pkg::*; #(
	parameter int MOTORS            = MOTORS_DEF,
	parameter int ANGLE_OUT_LIMIT   = ANGLE_LIMIT_DEF,
	parameter int SPEED_OUT_LIMIT   = SPEED_LIMIT_DEF,
	parameter int CURRENT_OUT_LIMIT = CURRENT_LIMIT_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dp_ctl_t              ctl,
	input  logic [1:0]           motor_index,
	input  logic [12:0]          angle_cmd,
	input  logic [12:0]          measured_angle,
	input  logic signed [15:0]   measured_speed,
	input  logic signed [15:0]   measured_current,
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [REG_W-1:0]     cfg_data,
	input  logic                 out_ready,
	output logic                 out_valid,
	output logic signed [12:0]   drive_current,
	output dp_stat_t             stat
);

	localparam int MW = (MOTORS > 1) ? $clog2(MOTORS) : 1;
	localparam logic signed [LIM_W-1:0] A_LIM = LIM_W'(ANGLE_OUT_LIMIT);
	localparam logic signed [LIM_W-1:0] S_LIM = LIM_W'(SPEED_OUT_LIMIT);
	localparam logic signed [LIM_W-1:0] C_LIM = LIM_W'(CURRENT_OUT_LIMIT);

	logic [REG_W-1:0] regs_q [NUM_REGS];

	logic [1:0]         motor_q;
	logic [12:0]        tgt_q;
	logic [12:0]        meas_q;
	logic signed [15:0] spd_q;
	logic signed [15:0] cur_q;

	logic signed [31:0] sum_q  [3][MOTORS];
	logic signed [16:0] last_q [3][MOTORS];

	logic signed [16:0] e_q;
	logic signed [31:0] s_q;
	logic signed [17:0] de_q;
	logic signed [65:0] prod_q;
	logic signed [67:0] acc_q;
	logic signed [15:0] res_q;
	logic               out_valid_q;
	logic signed [12:0] out_data_q;

	logic [MW+1:0]      motor_wide;
	logic [MW-1:0]      idx;
	logic signed [14:0] ang_diff;
	logic signed [14:0] ang_wrap;
	logic signed [16:0] e_new;
	logic signed [31:0] sum_rd;
	logic signed [16:0] last_rd;
	logic signed [33:0] s_wide;
	logic signed [31:0] s_sat;
	logic signed [17:0] de_new;
	logic [REG_W-1:0]   gain;
	logic signed [32:0] gain_s;
	logic signed [32:0] opnd;
	logic signed [65:0] prod_d;
	logic signed [67:0] acc_rnd;
	logic signed [43:0] rnd;
	logic signed [43:0] lim;
	logic signed [15:0] res_d;

	assign motor_wide = (MW + 2)'(motor_q);
	assign idx        = motor_wide[MW-1:0];
	assign stat.bad_motor = (motor_wide >= (MW + 2)'(MOTORS));
	assign stat.out_busy  = out_valid_q & ~out_ready;

	always_comb begin
		ang_diff = $signed({2'b00, tgt_q}) - $signed({2'b00, meas_q});
		ang_wrap = ang_diff;
		if (ang_diff > 15'sd4096) begin
			ang_wrap = ang_diff - 15'sd8192;
		end else if (ang_diff < -15'sd4096) begin
			ang_wrap = ang_diff + 15'sd8192;
		end
	end

	always_comb begin
		case (ctl.stage)
			STG_ANGLE: e_new = 17'(ang_wrap);
			STG_SPEED: e_new = 17'(res_q) - 17'(spd_q);
			default:   e_new = 17'(res_q) - 17'(cur_q);
		endcase
	end

	assign sum_rd  = sum_q[ctl.stage][idx];
	assign last_rd = last_q[ctl.stage][idx];
	assign s_wide  = 34'(sum_rd) + 34'(e_new);
	assign de_new  = 18'(e_new) - 18'(last_rd);

	always_comb begin
		if (s_wide > 34'sd2147483647) begin
			s_sat = 32'sh7FFFFFFF;
		end else if (s_wide < -34'sd2147483648) begin
			s_sat = 32'sh80000000;
		end else begin
			s_sat = s_wide[31:0];
		end
	end

	always_comb begin
		case (ctl.stage)
			STG_ANGLE: begin
				case (ctl.uw.term)
					TERM_P:  gain = regs_q[REG_ANGLE_KP];
					TERM_I:  gain = regs_q[REG_ANGLE_KI];
					default: gain = regs_q[REG_ANGLE_KD];
				endcase
				lim = 44'(A_LIM);
			end
			STG_SPEED: begin
				case (ctl.uw.term)
					TERM_P:  gain = regs_q[REG_SPEED_KP];
					TERM_I:  gain = regs_q[REG_SPEED_KI];
					default: gain = regs_q[REG_SPEED_KD];
				endcase
				lim = 44'(S_LIM);
			end
			default: begin
				case (ctl.uw.term)
					TERM_P:  gain = regs_q[REG_CURRENT_KP];
					TERM_I:  gain = regs_q[REG_CURRENT_KI];
					default: gain = CURRENT_KD_FIXED;
				endcase
				lim = 44'(C_LIM);
			end
		endcase
	end

	always_comb begin
		case (ctl.uw.term)
			TERM_P:  opnd = 33'(e_q);
			TERM_I:  opnd = 33'(s_q);
			default: opnd = 33'(de_q);
		endcase
	end

	assign gain_s = $signed({1'b0, gain});
	assign prod_d = gain_s * opnd;

	assign acc_rnd = acc_q + 68'sd8388608;
	assign rnd     = acc_rnd[67:24];

	always_comb begin
		if (rnd > lim) begin
			res_d = lim[15:0];
		end else if (rnd < -lim) begin
			res_d = -lim[15:0];
		end else begin
			res_d = rnd[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				regs_q[i] <= reg_reset(reg_idx_t'(i));
			end
		end else if (cfg_we) begin
			regs_q[cfg_index] <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < 3; s++) begin
				for (int m = 0; m < MOTORS; m++) begin
					sum_q[s][m]  <= '0;
					last_q[s][m] <= '0;
				end
			end
		end else if (ctl.uw.wb_en) begin
			sum_q[ctl.stage][idx]  <= s_q;
			last_q[ctl.stage][idx] <= e_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			motor_q <= motor_index;
			tgt_q   <= angle_cmd;
			meas_q  <= measured_angle;
			spd_q   <= measured_speed;
			cur_q   <= measured_current;
		end
		if (ctl.uw.err_en) begin
			e_q  <= e_new;
			s_q  <= s_sat;
			de_q <= de_new;
		end
		if (ctl.uw.mul_en) begin
			prod_q <= prod_d;
		end
		if (ctl.uw.acc_clr) begin
			acc_q <= '0;
		end else if (ctl.uw.acc_en) begin
			acc_q <= acc_q + 68'(prod_q);
		end
		if (ctl.uw.wb_en) begin
			res_q <= res_d;
		end
		if (ctl.uw.out_en) begin
			out_data_q <= ctl.uw.out_zero ? 13'sd0 : res_q[12:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.uw.out_en) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid     = out_valid_q;
	assign drive_current = out_data_q;

endmodule

### sv/cascaded_pid_position_loop.sv
`timescale 1ns / 1ps
// Each accepted item is processed to completion before the next one is taken: the
// 12-step microprogram walks three PID stages through one shared 33x33 multiplier,
// and an out-of-range motor index yields a zero drive current instead.
// A finished result waits in the output register while the next item is taken.
// arst_n clears the sequencer, output valid, gain registers (to their defaults)
// and all per-motor error sums and last errors.

module cascaded_pid_position_loop import cpl_pkg::*; #(
	parameter int MOTORS            = MOTORS_DEF,
	parameter int ANGLE_OUT_LIMIT   = ANGLE_LIMIT_DEF,
	parameter int SPEED_OUT_LIMIT   = SPEED_LIMIT_DEF,
	parameter int CURRENT_OUT_LIMIT = CURRENT_LIMIT_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// motor_index, target angle, measured_angle, measured_speed, measured_current
	input  logic [63:0]          s_axis_tdata,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// drive_current
	output logic [15:0]          m_axis_tdata,
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [REG_W-1:0]     cfg_data
);

	dp_ctl_t            ctl;
	dp_stat_t           stat;
	logic signed [12:0] drive_current;

	cpl_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.stat     (stat),
		.in_ready (s_axis_tready),
		.ctl      (ctl)
	);

	cpl_dp #(
		.MOTORS            (MOTORS),
		.ANGLE_OUT_LIMIT   (ANGLE_OUT_LIMIT),
		.SPEED_OUT_LIMIT   (SPEED_OUT_LIMIT),
		.CURRENT_OUT_LIMIT (CURRENT_OUT_LIMIT)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.ctl              (ctl),
		.motor_index      (s_axis_tdata[1:0]),
		.angle_cmd        (s_axis_tdata[14:2]),
		.measured_angle   (s_axis_tdata[27:15]),
		.measured_speed   (s_axis_tdata[43:28]),
		.measured_current (s_axis_tdata[59:44]),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.out_ready        (m_axis_tready),
		.out_valid        (m_axis_tvalid),
		.drive_current    (drive_current),
		.stat             (stat)
	);

	assign m_axis_tdata = {3'b000, drive_current};

endmodule
